[hw/rtl/bmhpq_pkg.sv]
// bmhpq_pkg: shared widths, operation and status codes, and the command and
// status structs passed between the heap controller and its datapath.
// No dependencies.
`default_nettype none

package bmhpq_pkg;

  localparam int unsigned DEPTH_DEF = 256;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned CNT_W     = 9;          // count, position and capacity width
  localparam int unsigned IDX_W     = CNT_W + 1;  // heap index, room for 2i+1
  localparam logic [CNT_W-1:0] CAP_RST = 9'd256;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_EXTRACT  = 2'd1,
    OP_INCREASE = 2'd2,
    OP_DELETE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_BAD_POS = 3'd3,
    ST_SMALLER = 3'd4
  } status_e;

  // read address source
  typedef enum logic [2:0] {
    RA_POS,
    RA_LAST,
    RA_PARENT,
    RA_LEFT,
    RA_RIGHT,
    RA_ROOT
  } rd_sel_e;

  // write data source, written at the hole
  typedef enum logic [1:0] {
    WD_KEY,
    WD_RDATA,
    WD_BEST
  } wd_sel_e;

  // next hole index source
  typedef enum logic [2:0] {
    HS_POS,
    HS_NEXT,
    HS_ROOT,
    HS_PARENT,
    HS_BEST
  } hole_sel_e;

  typedef struct packed {
    logic      latch;
    logic      rd_en;
    rd_sel_e   rd_sel;
    logic      wr_en;
    wd_sel_e   wd_sel;
    logic      hole_ld;
    hole_sel_e hole_sel;
    logic      v_ld;
    logic      v_from_rd;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      lval_ld;
    logic      ext_ld;
    logic      st_ld;
    status_e   st_val;
    logic      emit;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic full;
    logic empty;
    logic pos_bad;
    logic key_smaller;
    logic at_root;
    logic at_end;
    logic left_in;
    logic right_in;
    logic up_move;
    logic dn_move;
  } dp_stat_t;

endpackage

`default_nettype wire

[hw/rtl/bmhpq_datapath.sv]
// bmhpq_datapath: key memory, count and capacity registers, hole index,
// moving key, compares and result registers of the heap.
// Depends on bmhpq_pkg.
`default_nettype none

module bmhpq_datapath #(
  parameter int unsigned DEPTH = bmhpq_pkg::DEPTH_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic [1:0]                             op_i,
  input  wire logic signed [bmhpq_pkg::KEY_W-1:0]     key_value_i,
  input  wire logic [bmhpq_pkg::CNT_W-1:0]            position_i,
  input  wire logic                                   cfg_we_i,
  input  wire logic [bmhpq_pkg::CNT_W-1:0]            cfg_wdata_i,
  input  wire bmhpq_pkg::dp_cmd_t                     cmd_i,
  output      bmhpq_pkg::dp_stat_t                    stat_o,
  output      logic signed [bmhpq_pkg::KEY_W-1:0]     out_value_o,
  output      logic [2:0]                             status_o,
  output      logic [bmhpq_pkg::CNT_W-1:0]            count_o,
  output      logic                                   done_o
);

  localparam int unsigned KW = bmhpq_pkg::KEY_W;
  localparam int unsigned CW = bmhpq_pkg::CNT_W;
  localparam int unsigned IW = bmhpq_pkg::IDX_W;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [CW-1:0] DEPTH_LIM =
    (DEPTH > ((2 ** CW) - 1)) ? {CW{1'b1}} : CW'(DEPTH);

  // 1-based heap index to memory address
  function automatic logic [AW-1:0] to_addr(input logic [IW-1:0] idx);
    logic [IW+AW-1:0] w;
    w = {{AW{1'b0}}, idx} - (IW+AW)'(1);
    return w[AW-1:0];
  endfunction

  logic [KW-1:0] mem_q [DEPTH];

  bmhpq_pkg::op_e       op_q;
  logic signed [KW-1:0] key_q;
  logic [CW-1:0]        pos_q;
  logic [CW-1:0]        cnt_q;
  logic [CW-1:0]        cap_q;
  logic [IW-1:0]        hole_q;
  logic signed [KW-1:0] v_q;
  logic signed [KW-1:0] lval_q;
  logic signed [KW-1:0] rdata_q;
  logic signed [KW-1:0] ext_q;
  logic                 has_ext_q;
  bmhpq_pkg::status_e   st_q;
  logic signed [KW-1:0] out_value_q;
  logic [2:0]           status_q;
  logic [CW-1:0]        count_q;
  logic                 done_q;

  logic [CW-1:0]        limit;
  logic [IW-1:0]        cnt_x;
  logic [IW-1:0]        left_idx;
  logic [IW-1:0]        right_idx;
  logic [IW-1:0]        parent_idx;
  logic [IW-1:0]        rd_idx;
  logic [IW-1:0]        hole_d;
  logic signed [KW-1:0] wdata;
  logic signed [KW-1:0] ref_val;
  logic                 l_gt_v;
  logic                 pick_r;

  assign limit      = (cap_q < DEPTH_LIM) ? cap_q : DEPTH_LIM;
  assign cnt_x      = {1'b0, cnt_q};
  assign left_idx   = {hole_q[IW-2:0], 1'b0};
  assign right_idx  = {hole_q[IW-2:0], 1'b1};
  assign parent_idx = {1'b0, hole_q[IW-1:1]};

  assign l_gt_v  = lval_q > v_q;
  assign ref_val = l_gt_v ? lval_q : v_q;
  assign pick_r  = (right_idx <= cnt_x) && (rdata_q > ref_val);

  always_comb begin
    stat_o.op          = op_q;
    stat_o.full        = cnt_q >= limit;
    stat_o.empty       = cnt_q == '0;
    stat_o.pos_bad     = (pos_q == '0) || (pos_q > cnt_q);
    stat_o.key_smaller = key_q < rdata_q;
    stat_o.at_root     = hole_q == IW'(1);
    stat_o.at_end      = hole_q == cnt_x;
    stat_o.left_in     = left_idx <= cnt_x;
    stat_o.right_in    = right_idx <= cnt_x;
    stat_o.up_move     = v_q > rdata_q;
    stat_o.dn_move     = l_gt_v || pick_r;
  end

  always_comb begin
    unique case (cmd_i.rd_sel)
      bmhpq_pkg::RA_POS:    rd_idx = {1'b0, pos_q};
      bmhpq_pkg::RA_LAST:   rd_idx = cnt_x;
      bmhpq_pkg::RA_PARENT: rd_idx = parent_idx;
      bmhpq_pkg::RA_LEFT:   rd_idx = left_idx;
      bmhpq_pkg::RA_RIGHT:  rd_idx = right_idx;
      default:              rd_idx = IW'(1);
    endcase
  end

  always_comb begin
    unique case (cmd_i.wd_sel)
      bmhpq_pkg::WD_RDATA: wdata = rdata_q;
      bmhpq_pkg::WD_BEST:  wdata = pick_r ? rdata_q : lval_q;
      default:             wdata = v_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.hole_sel)
      bmhpq_pkg::HS_POS:    hole_d = {1'b0, pos_q};
      bmhpq_pkg::HS_NEXT:   hole_d = cnt_x + IW'(1);
      bmhpq_pkg::HS_PARENT: hole_d = parent_idx;
      bmhpq_pkg::HS_BEST:   hole_d = pick_r ? right_idx : left_idx;
      default:              hole_d = IW'(1);
    endcase
  end

  // key memory: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[to_addr(hole_q)] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[to_addr(rd_idx)];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= bmhpq_pkg::op_e'(op_i);
      key_q <= key_value_i;
      pos_q <= position_i;
    end
    if (cmd_i.hole_ld) begin
      hole_q <= hole_d;
    end
    if (cmd_i.v_ld) begin
      v_q <= cmd_i.v_from_rd ? rdata_q : key_q;
    end
    if (cmd_i.lval_ld) begin
      lval_q <= rdata_q;
    end
    if (cmd_i.ext_ld) begin
      ext_q <= rdata_q;
    end
    if (cmd_i.emit) begin
      out_value_q <= has_ext_q ? ext_q : ((cnt_q != '0) ? rdata_q : '0);
      status_q    <= st_q;
      count_q     <= cnt_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      cap_q     <= bmhpq_pkg::CAP_RST;
      has_ext_q <= 1'b0;
      st_q      <= bmhpq_pkg::ST_OK;
      done_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_q - CW'(1);
      end
      if (cmd_i.latch) begin
        has_ext_q <= 1'b0;
        st_q      <= bmhpq_pkg::ST_OK;
      end else begin
        if (cmd_i.ext_ld) begin
          has_ext_q <= 1'b1;
        end
        if (cmd_i.st_ld) begin
          st_q <= cmd_i.st_val;
        end
      end
      done_q <= cmd_i.emit;
    end
  end

  assign out_value_o = out_value_q;
  assign status_o    = status_q;
  assign count_o     = count_q;
  assign done_o      = done_q;

endmodule

`default_nettype wire

[hw/rtl/bmhpq_ctrl.sv]
// bmhpq_ctrl: sequencer for insert, extract, increase and delete, driving
// the datapath with sift-up and sift-down steps.
// Depends on bmhpq_pkg.
`default_nettype none

module bmhpq_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output      logic                 busy_o,
  input  wire bmhpq_pkg::dp_stat_t  stat_i,
  output      bmhpq_pkg::dp_cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INC_CMP,
    S_EXT_GET,
    S_DEL_LAST,
    S_UP_RD,
    S_UP_CMP,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_TOP_RD,
    S_REPORT
  } state_e;

  state_e state_q, state_d;
  logic   moved_q, moved_d;

  assign busy_o = state_q != S_IDLE;

  always_comb begin
    state_d = state_q;
    moved_d = moved_q;
    cmd_o   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end

      S_DECODE: begin
        unique case (stat_i.op)
          bmhpq_pkg::OP_INSERT: begin
            if (stat_i.full) begin
              cmd_o.st_ld  = 1'b1;
              cmd_o.st_val = bmhpq_pkg::ST_FULL;
              state_d      = S_TOP_RD;
            end else begin
              cmd_o.cnt_inc  = 1'b1;
              cmd_o.hole_ld  = 1'b1;
              cmd_o.hole_sel = bmhpq_pkg::HS_NEXT;
              cmd_o.v_ld     = 1'b1;
              state_d        = S_UP_RD;
            end
          end
          bmhpq_pkg::OP_EXTRACT: begin
            if (stat_i.empty) begin
              cmd_o.st_ld  = 1'b1;
              cmd_o.st_val = bmhpq_pkg::ST_EMPTY;
              state_d      = S_TOP_RD;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = bmhpq_pkg::RA_ROOT;
              state_d      = S_EXT_GET;
            end
          end
          default: begin
            if (stat_i.pos_bad) begin
              cmd_o.st_ld  = 1'b1;
              cmd_o.st_val = bmhpq_pkg::ST_BAD_POS;
              state_d      = S_TOP_RD;
            end else if (stat_i.op == bmhpq_pkg::OP_INCREASE) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = bmhpq_pkg::RA_POS;
              state_d      = S_INC_CMP;
            end else begin
              cmd_o.hole_ld  = 1'b1;
              cmd_o.hole_sel = bmhpq_pkg::HS_POS;
              cmd_o.rd_en    = 1'b1;
              cmd_o.rd_sel   = bmhpq_pkg::RA_LAST;
              state_d        = S_DEL_LAST;
            end
          end
        endcase
      end

      S_INC_CMP: begin
        if (stat_i.key_smaller) begin
          cmd_o.st_ld  = 1'b1;
          cmd_o.st_val = bmhpq_pkg::ST_SMALLER;
          state_d      = S_TOP_RD;
        end else begin
          cmd_o.hole_ld  = 1'b1;
          cmd_o.hole_sel = bmhpq_pkg::HS_POS;
          cmd_o.v_ld     = 1'b1;
          state_d        = S_UP_RD;
        end
      end

      S_EXT_GET: begin
        cmd_o.ext_ld   = 1'b1;
        cmd_o.hole_ld  = 1'b1;
        cmd_o.hole_sel = bmhpq_pkg::HS_ROOT;
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sel   = bmhpq_pkg::RA_LAST;
        state_d        = S_DEL_LAST;
      end

      S_DEL_LAST: begin
        cmd_o.v_ld      = 1'b1;
        cmd_o.v_from_rd = 1'b1;
        cmd_o.cnt_dec   = 1'b1;
        moved_d         = 1'b0;
        // removing the last slot itself leaves nothing to move
        state_d         = stat_i.at_end ? S_TOP_RD : S_DN_L;
      end

      S_UP_RD: begin
        if (stat_i.at_root) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wd_sel = bmhpq_pkg::WD_KEY;
          state_d      = S_TOP_RD;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = bmhpq_pkg::RA_PARENT;
          state_d      = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.up_move) begin
          cmd_o.wd_sel   = bmhpq_pkg::WD_RDATA;
          cmd_o.hole_ld  = 1'b1;
          cmd_o.hole_sel = bmhpq_pkg::HS_PARENT;
          state_d        = S_UP_RD;
        end else begin
          cmd_o.wd_sel = bmhpq_pkg::WD_KEY;
          state_d      = S_TOP_RD;
        end
      end

      S_DN_L: begin
        if (stat_i.left_in) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = bmhpq_pkg::RA_LEFT;
          state_d      = S_DN_R;
        end else if (moved_q) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wd_sel = bmhpq_pkg::WD_KEY;
          state_d      = S_TOP_RD;
        end else begin
          state_d = S_UP_RD;
        end
      end

      S_DN_R: begin
        cmd_o.lval_ld = 1'b1;
        cmd_o.rd_en   = stat_i.right_in;
        cmd_o.rd_sel  = bmhpq_pkg::RA_RIGHT;
        state_d       = S_DN_CMP;
      end

      S_DN_CMP: begin
        if (stat_i.dn_move) begin
          cmd_o.wr_en    = 1'b1;
          cmd_o.wd_sel   = bmhpq_pkg::WD_BEST;
          cmd_o.hole_ld  = 1'b1;
          cmd_o.hole_sel = bmhpq_pkg::HS_BEST;
          moved_d        = 1'b1;
          state_d        = S_DN_L;
        end else if (moved_q) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wd_sel = bmhpq_pkg::WD_KEY;
          state_d      = S_TOP_RD;
        end else begin
          state_d = S_UP_RD;
        end
      end

      S_TOP_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = bmhpq_pkg::RA_ROOT;
        state_d      = S_REPORT;
      end

      S_REPORT: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      moved_q <= 1'b0;
    end else begin
      state_q <= state_d;
      moved_q <= moved_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/binary_max_heap_priority_queue.sv]
// binary_max_heap_priority_queue: top level of the max-heap priority queue,
// joining the sequencer bmhpq_ctrl and the datapath bmhpq_datapath.
// Depends on bmhpq_pkg, bmhpq_ctrl and bmhpq_datapath.
//
//   channel   ports                                    handshake
//   --------  ---------------------------------------  -------------------------
//   request   op_i, key_value_i, position_i            taken when start & !busy
//   result    out_value_o, status_o, count_o           shown one cycle, done_o
//   config    cfg_wdata_i (capacity limit)             written when cfg_we_i
//
// one item at a time; busy is high from the cycle after acceptance until the
// result has been handed to the output registers
// busy time per item grows with the levels that the key climbs (insert,
// increase, and delete when the moved key climbs) or sinks (extract,
// delete); refused items skip the heap walk; the single read port of the
// key memory sets this, one heap slot fetched at a time
// done_o rises in the first cycle with busy low; the receiver cannot stall it
// reset clears the count and restores the capacity limit to 256; the key
// memory is not cleared, only slots up to the count are ever used
`default_nettype none

module binary_max_heap_priority_queue #(
  parameter int unsigned DEPTH = bmhpq_pkg::DEPTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // request
  input  wire logic                                start,
  output      logic                                busy,
  input  wire logic [1:0]                          op_i,
  input  wire logic signed [bmhpq_pkg::KEY_W-1:0]  key_value_i,
  input  wire logic [bmhpq_pkg::CNT_W-1:0]         position_i,
  // capacity limit
  input  wire logic                                cfg_we_i,
  input  wire logic [bmhpq_pkg::CNT_W-1:0]         cfg_wdata_i,
  // result
  output      logic                                done_o,
  output      logic signed [bmhpq_pkg::KEY_W-1:0]  out_value_o,
  output      logic [2:0]                          status_o,
  output      logic [bmhpq_pkg::CNT_W-1:0]         count_o
);

  bmhpq_pkg::dp_cmd_t  cmd;
  bmhpq_pkg::dp_stat_t stat;

  // sequencer: walks each operation one heap slot at a time
  bmhpq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  // key memory, count, hole and moving key, result registers
  bmhpq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op_i),
    .key_value_i (key_value_i),
    .position_i  (position_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_value_o (out_value_o),
    .status_o    (status_o),
    .count_o     (count_o),
    .done_o      (done_o)
  );

endmodule

`default_nettype wire

[hw/rtl/bmhpq_checker.sv]
// bmhpq_checker: port-level checks on the heap priority queue, bound to the
// top level. Depends on bmhpq_pkg and binary_max_heap_priority_queue.
`default_nettype none

module bmhpq_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                start,
  input wire logic                                busy,
  input wire logic                                done_o,
  input wire logic signed [bmhpq_pkg::KEY_W-1:0]  out_value_o,
  input wire logic [2:0]                          status_o,
  input wire logic [bmhpq_pkg::CNT_W-1:0]         count_o
);

  // an accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // results come singly, never in two adjacent cycles
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two results in adjacent cycles");

  // a result appears only once the sequencer has gone idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // an empty extract reports nothing held and a zero value
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == bmhpq_pkg::ST_EMPTY) |-> (count_o == '0) && (out_value_o == '0))
    else $error("empty status with keys or value");

endmodule

bind binary_max_heap_priority_queue bmhpq_checker u_bmhpq_checker (.*);

`default_nettype wire
